@@ hdl/rprg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the reference-counted power rail gate.
// No dependencies; used by every module of the block except rprg_ram.
package rprg_pkg;

  localparam int NumRailsDflt    = 192;
  localparam int BitsPerWordDflt = 32;

  localparam int RailW   = 8;
  localparam int CountW  = 8;
  localparam int WordW   = 3;
  localparam int BitW    = 5;

  localparam logic [CountW-1:0] CountMax = 8'hFF;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_RAIL  = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_SATURATED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE       = 2'd0,
    ACT_POWER_UP   = 2'd1,
    ACT_POWER_DOWN = 2'd2
  } action_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

@@ hdl/refcounted_power_rail_gate_top.sv @@
`timescale 1ns / 1ps
// For each request, the cycle it is accepted issues the read of the rail's count from the
// count RAM (registered read); the execute state then waits until the output slot is free,
// and then updates the count, writes it back and loads the result register; a new request is
// accepted in the cycle after that, while the previous result may still wait at the output.
// Counts are cleared at reset by per-rail valid bits, so there is no clearing pass. An
// out-of-range rail returns status 1 with all other fields zero; a release at count zero and a
// request at count 255 are flagged and leave the count unchanged.
// Top level; depends on rprg_pkg, rprg_ctrl and rprg_dp, and on rprg_ram through rprg_dp.
module refcounted_power_rail_gate_top #(
  parameter int NumRails    = rprg_pkg::NumRailsDflt,
  parameter int BitsPerWord = rprg_pkg::BitsPerWordDflt
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [rprg_pkg::RailW-1:0]  rail_id_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [1:0]                  action_o,
  output logic [rprg_pkg::WordW-1:0]  word_index_o,
  output logic [rprg_pkg::BitW-1:0]   bit_index_o,
  output logic [rprg_pkg::CountW-1:0] new_count_o
);

  rprg_pkg::cmd_t cmd;

  rprg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  rprg_dp #(
    .NumRails    (NumRails),
    .BitsPerWord (BitsPerWord)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (op_i),
    .rail_id_i    (rail_id_i),
    .status_o     (status_o),
    .action_o     (action_o),
    .word_index_o (word_index_o),
    .bit_index_o  (bit_index_o),
    .new_count_o  (new_count_o)
  );

endmodule

@@ hdl/rprg_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rprg_ram #(
  parameter int Width = 8,
  parameter int Depth = 192,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/rprg_ctrl.sv @@
`timescale 1ns / 1ps
// Controller for the power rail gate: request sequencing and output handshake.
// Depends on rprg_pkg.
module rprg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rprg_pkg::cmd_t cmd_o
);

  rprg_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rprg_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = rprg_pkg::S_EXEC;
        end
      end
      rprg_pkg::S_EXEC: begin
        if (slot_free) begin
          state_d = rprg_pkg::S_IDLE;
        end
      end
      default: state_d = rprg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o     = 1'b1;
    cmd_o.capture  = 1'b0;
    cmd_o.commit   = 1'b0;
    unique case (state_q)
      rprg_pkg::S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      rprg_pkg::S_EXEC: begin
        cmd_o.commit = slot_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rprg_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == rprg_pkg::S_EXEC))
    else $error("accepted request did not enter execute");
  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !(out_valid_q && out_stall_i))
    else $error("result overwrote a stalled result");
  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented");
`endif

endmodule

@@ hdl/rprg_dp.sv @@
`timescale 1ns / 1ps
// Datapath for the power rail gate: count memory, valid bits, update and result registers.
// Depends on rprg_pkg and rprg_ram.
module rprg_dp #(
  parameter int NumRails    = rprg_pkg::NumRailsDflt,
  parameter int BitsPerWord = rprg_pkg::BitsPerWordDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rprg_pkg::cmd_t                cmd_i,
  input  logic                          op_i,
  input  logic [rprg_pkg::RailW-1:0]    rail_id_i,
  output logic [1:0]                    status_o,
  output logic [1:0]                    action_o,
  output logic [rprg_pkg::WordW-1:0]    word_index_o,
  output logic [rprg_pkg::BitW-1:0]     bit_index_o,
  output logic [rprg_pkg::CountW-1:0]   new_count_o
);

  localparam int AddrW = (NumRails > 1) ? $clog2(NumRails) : 1;

  logic                          op_q;
  logic [rprg_pkg::RailW-1:0]    rail_q;
  logic [AddrW-1:0]              addr_q;
  logic [NumRails-1:0]           valid_q;
  logic [rprg_pkg::CountW-1:0]   rdata;
  logic [rprg_pkg::CountW-1:0]   cur;
  logic                          rail_ok;
  logic                          we;

  rprg_pkg::status_e             status_d, status_q;
  rprg_pkg::action_e             action_d, action_q;
  logic [rprg_pkg::CountW-1:0]   count_d, count_q;
  logic [rprg_pkg::WordW-1:0]    word_d, word_q;
  logic [rprg_pkg::BitW-1:0]     bit_d, bit_q;

  logic [rprg_pkg::WordW-1:0]    word_lut [NumRails];
  logic [rprg_pkg::BitW-1:0]     bit_lut  [NumRails];

  for (genvar i = 0; i < NumRails; i++) begin : g_lut
    assign word_lut[i] = rprg_pkg::WordW'((i / BitsPerWord) % 8);
    assign bit_lut[i]  = rprg_pkg::BitW'(i % BitsPerWord);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      rail_q <= rail_id_i;
    end
  end

  assign addr_q  = rail_q[AddrW-1:0];
  assign rail_ok = {1'b0, rail_q} < 9'(NumRails);

  rprg_ram #(
    .Width (rprg_pkg::CountW),
    .Depth (NumRails)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (count_d),
    .re_i    (cmd_i.capture),
    .raddr_i (rail_id_i[AddrW-1:0]),
    .rdata_o (rdata)
  );

  assign cur = (rail_ok && valid_q[addr_q]) ? rdata : '0;

  always_comb begin
    status_d = rprg_pkg::STATUS_OK;
    action_d = rprg_pkg::ACT_NONE;
    count_d  = cur;
    word_d   = '0;
    bit_d    = '0;
    if (!rail_ok) begin
      status_d = rprg_pkg::STATUS_BAD_RAIL;
      count_d  = '0;
    end else begin
      word_d = word_lut[addr_q];
      bit_d  = bit_lut[addr_q];
      if (op_q == rprg_pkg::OP_REQUEST) begin
        if (cur == rprg_pkg::CountMax) begin
          status_d = rprg_pkg::STATUS_SATURATED;
        end else begin
          if (cur == '0) begin
            action_d = rprg_pkg::ACT_POWER_UP;
          end
          count_d = cur + 1'b1;
        end
      end else begin
        if (cur == '0) begin
          status_d = rprg_pkg::STATUS_UNDERFLOW;
        end else begin
          if (cur == rprg_pkg::CountW'(1)) begin
            action_d = rprg_pkg::ACT_POWER_DOWN;
          end
          count_d = cur - 1'b1;
        end
      end
    end
  end

  assign we = cmd_i.commit && (status_d == rprg_pkg::STATUS_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      action_q <= action_d;
      count_q  <= count_d;
      word_q   <= word_d;
      bit_q    <= bit_d;
    end
  end

  assign status_o     = status_q;
  assign action_o     = action_q;
  assign new_count_o  = count_q;
  assign word_index_o = word_q;
  assign bit_index_o  = bit_q;

`ifndef SYNTHESIS
  a_write_valid_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> rail_ok)
    else $error("count write to an invalid rail");
  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> valid_q[$past(addr_q)])
    else $error("written count not marked valid");
`endif

endmodule
